// ===== hw/rtl/sorted_set_merge_op_defines.svh =====
// Assertion macros shared by the RTL of the sorted set merge block.
// Each macro expects the signals clk and rst_n to be visible at the place of use.
`ifndef SORTED_SET_MERGE_OP_DEFINES_SVH
`define SORTED_SET_MERGE_OP_DEFINES_SVH

`ifndef ASSERT_OFF
// The condition must hold at every clock edge outside reset.
`define SSM_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// When the antecedent holds, the consequent must hold in the cycle after.
`define SSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SSM_ASSERT(lbl, cond, msg)
`define SSM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/ssm_pkg.sv =====
package ssm_pkg;

  // Maximum number of elements kept per set.
  localparam int SET_DEPTH = 32;
  localparam int ADDR_W    = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
  localparam int CNT_W     = $clog2(SET_DEPTH + 1);
  localparam int VAL_W     = 64;
  localparam int MODE_W    = 2;

  localparam logic [MODE_W-1:0] MODE_UNION     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INTERSECT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DIFF      = 2'd2;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_PRIME,
    ST_MERGE
  } ssm_state_t;

  typedef struct packed {
    logic                    set_sel;
    logic signed [VAL_W-1:0] elem_value;
    logic                    elem_last;
  } ssm_in_beat_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] out_value;
    logic                    out_last;
    logic                    result_empty;
    logic                    overflow;
  } ssm_out_beat_t;

endpackage

// ===== hw/rtl/ssm_store.sv =====
// Element storage for both sets: one write port shared by the sets and one
// registered read port per set.
module ssm_store (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic                                wr_sel,
  input  logic [ssm_pkg::ADDR_W-1:0]          wr_addr,
  input  logic signed [ssm_pkg::VAL_W-1:0]    wr_data,
  input  logic [ssm_pkg::ADDR_W-1:0]          rd_addr_a,
  input  logic [ssm_pkg::ADDR_W-1:0]          rd_addr_b,
  output logic signed [ssm_pkg::VAL_W-1:0]    rd_data_a,
  output logic signed [ssm_pkg::VAL_W-1:0]    rd_data_b
);

  logic signed [ssm_pkg::VAL_W-1:0] mem_a [ssm_pkg::SET_DEPTH];
  logic signed [ssm_pkg::VAL_W-1:0] mem_b [ssm_pkg::SET_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en && !wr_sel) begin
      mem_a[wr_addr] <= wr_data;
    end
    if (wr_en && wr_sel) begin
      mem_b[wr_addr] <= wr_data;
    end
    rd_data_a <= mem_a[rd_addr_a];
    rd_data_b <= mem_b[rd_addr_b];
  end

endmodule

// ===== hw/rtl/sorted_set_merge_op.sv =====
// Channel   Direction  Handshake              Payload
// in_       input      start high, busy low   ssm_in_beat_t  (set_sel, elem_value, elem_last)
// out_      output     out_valid strobe       ssm_out_beat_t (out_value, out_last,
//                                                             result_empty, overflow)
// cfg_      input      cfg_valid, cfg_ready   op_mode, 2 bits
//
// Element beats load at one per cycle while the block is in its load phase.
// The beat that ends the second of the two sets starts the merge: busy is high through
// the priming state of the store read port and then through the merge steps, each of
// which advances one or both read pointers by one entry, save the step that finishes.
// At most one result beat leaves per cycle; it is shown for a single cycle and the
// receiver cannot stall it. Reset (rst_n low, synchronous) empties both sets and selects
// union; the store contents are not cleared, only the fill counts.
`include "sorted_set_merge_op_defines.svh"

module sorted_set_merge_op (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  ssm_pkg::ssm_in_beat_t         in_beat,
  output logic                          out_valid,
  output ssm_pkg::ssm_out_beat_t        out_beat,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ssm_pkg::MODE_W-1:0]    cfg_data
);

  ssm_pkg::ssm_state_t state_r, state_nxt;

  logic [ssm_pkg::MODE_W-1:0] mode_r;

  // Fill counts, end marks and the drop flag of the operation being loaded.
  logic [ssm_pkg::CNT_W-1:0] cnt_a_r, cnt_a_nxt;
  logic [ssm_pkg::CNT_W-1:0] cnt_b_r, cnt_b_nxt;
  logic                      done_a_r, done_a_nxt;
  logic                      done_b_r, done_b_nxt;
  logic                      drop_r, drop_nxt;

  // Merge read pointers.
  logic [ssm_pkg::CNT_W-1:0] i_r, i_nxt;
  logic [ssm_pkg::CNT_W-1:0] j_r, j_nxt;

  // One result is held back so that the final one can carry the last mark.
  logic signed [ssm_pkg::VAL_W-1:0] pend_r, pend_nxt;
  logic                             pend_vld_r, pend_vld_nxt;

  logic                   out_valid_r, out_valid_nxt;
  ssm_pkg::ssm_out_beat_t out_beat_r, out_beat_nxt;

  logic                             in_accept;
  logic                             wr_en;
  logic [ssm_pkg::ADDR_W-1:0]       wr_addr;
  logic signed [ssm_pkg::VAL_W-1:0] rd_a, rd_b;
  logic                             a_avail, b_avail;
  logic                             keep_a, keep_b, keep_both;
  logic                             emit, finish;
  logic signed [ssm_pkg::VAL_W-1:0] emit_val;

  assign busy      = (state_r != ssm_pkg::ST_LOAD);
  assign cfg_ready = (state_r == ssm_pkg::ST_LOAD);
  assign in_accept = start && !busy;
  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  // Mode decode. The unused code behaves as difference.
  assign keep_a    = (mode_r != ssm_pkg::MODE_INTERSECT);
  assign keep_b    = (mode_r == ssm_pkg::MODE_UNION);
  assign keep_both = (mode_r == ssm_pkg::MODE_UNION) || (mode_r == ssm_pkg::MODE_INTERSECT);

  assign a_avail = (i_r < cnt_a_r);
  assign b_avail = (j_r < cnt_b_r);

  // The read addresses follow the next pointers, so the registered read data always
  // belongs to the current pointers during the merge.
  ssm_store u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_sel    (in_beat.set_sel),
    .wr_addr   (wr_addr),
    .wr_data   (in_beat.elem_value),
    .rd_addr_a (i_nxt[ssm_pkg::ADDR_W-1:0]),
    .rd_addr_b (j_nxt[ssm_pkg::ADDR_W-1:0]),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_a_nxt     = cnt_a_r;
    cnt_b_nxt     = cnt_b_r;
    done_a_nxt    = done_a_r;
    done_b_nxt    = done_b_r;
    drop_nxt      = drop_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    pend_nxt      = pend_r;
    pend_vld_nxt  = pend_vld_r;
    out_valid_nxt = 1'b0;
    out_beat_nxt  = out_beat_r;
    wr_en         = 1'b0;
    wr_addr       = '0;
    emit          = 1'b0;
    finish        = 1'b0;
    emit_val      = rd_a;

    unique case (state_r)
      ssm_pkg::ST_LOAD: begin
        i_nxt        = '0;
        j_nxt        = '0;
        pend_vld_nxt = 1'b0;
        if (in_accept) begin
          // A beat for a set that has already ended is ignored.
          if (!in_beat.set_sel) begin
            if (!done_a_r) begin
              if (cnt_a_r < ssm_pkg::CNT_W'(ssm_pkg::SET_DEPTH)) begin
                wr_en     = 1'b1;
                wr_addr   = cnt_a_r[ssm_pkg::ADDR_W-1:0];
                cnt_a_nxt = cnt_a_r + 1'b1;
              end else begin
                drop_nxt = 1'b1;
              end
              if (in_beat.elem_last) begin
                done_a_nxt = 1'b1;
              end
            end
          end else begin
            if (!done_b_r) begin
              if (cnt_b_r < ssm_pkg::CNT_W'(ssm_pkg::SET_DEPTH)) begin
                wr_en     = 1'b1;
                wr_addr   = cnt_b_r[ssm_pkg::ADDR_W-1:0];
                cnt_b_nxt = cnt_b_r + 1'b1;
              end else begin
                drop_nxt = 1'b1;
              end
              if (in_beat.elem_last) begin
                done_b_nxt = 1'b1;
              end
            end
          end
          if (done_a_nxt && done_b_nxt) begin
            state_nxt = ssm_pkg::ST_PRIME;
          end
        end
      end

      // The last write has landed; this cycle reads the heads of both sets.
      ssm_pkg::ST_PRIME: begin
        state_nxt = ssm_pkg::ST_MERGE;
      end

      ssm_pkg::ST_MERGE: begin
        priority if (a_avail && b_avail) begin
          if (rd_a == rd_b) begin
            emit     = keep_both;
            emit_val = rd_a;
            i_nxt    = i_r + 1'b1;
            j_nxt    = j_r + 1'b1;
          end else if (rd_a < rd_b) begin
            emit     = keep_a;
            emit_val = rd_a;
            i_nxt    = i_r + 1'b1;
          end else begin
            emit     = keep_b;
            emit_val = rd_b;
            j_nxt    = j_r + 1'b1;
          end
        end else if (a_avail && keep_a) begin
          emit     = 1'b1;
          emit_val = rd_a;
          i_nxt    = i_r + 1'b1;
        end else if (b_avail && keep_b) begin
          emit     = 1'b1;
          emit_val = rd_b;
          j_nxt    = j_r + 1'b1;
        end else begin
          finish = 1'b1;
        end

        // A new result pushes the held one out.
        if (emit) begin
          pend_nxt     = emit_val;
          pend_vld_nxt = 1'b1;
          if (pend_vld_r) begin
            out_valid_nxt             = 1'b1;
            out_beat_nxt.out_value    = pend_r;
            out_beat_nxt.out_last     = 1'b0;
            out_beat_nxt.result_empty = 1'b0;
            out_beat_nxt.overflow     = drop_r;
          end
        end

        // The held result leaves marked last; with none held, an empty beat leaves.
        if (finish) begin
          out_valid_nxt             = 1'b1;
          out_beat_nxt.out_value    = pend_vld_r ? pend_r : '0;
          out_beat_nxt.out_last     = 1'b1;
          out_beat_nxt.result_empty = !pend_vld_r;
          out_beat_nxt.overflow     = drop_r;
          pend_vld_nxt              = 1'b0;
          cnt_a_nxt                 = '0;
          cnt_b_nxt                 = '0;
          done_a_nxt                = 1'b0;
          done_b_nxt                = 1'b0;
          drop_nxt                  = 1'b0;
          state_nxt                 = ssm_pkg::ST_LOAD;
        end
      end

      default: begin
        state_nxt = ssm_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ssm_pkg::ST_LOAD;
      mode_r      <= ssm_pkg::MODE_UNION;
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      done_a_r    <= 1'b0;
      done_b_r    <= 1'b0;
      drop_r      <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_a_r     <= cnt_a_nxt;
      cnt_b_r     <= cnt_b_nxt;
      done_a_r    <= done_a_nxt;
      done_b_r    <= done_b_nxt;
      drop_r      <= drop_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        mode_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_r     <= pend_nxt;
    out_beat_r <= out_beat_nxt;
  end

  // Result beats come only out of a merge step.
  `SSM_ASSERT_NEXT(a_out_from_merge, state_r != ssm_pkg::ST_MERGE, !out_valid_r, "result beat outside merge")
  // An empty result is always the final beat.
  `SSM_ASSERT(a_empty_is_last, !(out_valid_r && out_beat_r.result_empty) || out_beat_r.out_last, "empty beat not marked last")
  // The merge pointers never run past the fill counts.
  `SSM_ASSERT(a_ptr_in_range, state_r != ssm_pkg::ST_MERGE || (i_r <= cnt_a_r && j_r <= cnt_b_r), "merge pointer past count")
  // The final beat coincides with a return to an empty load phase.
  `SSM_ASSERT(a_last_clears, !(out_valid_r && out_beat_r.out_last) || (state_r == ssm_pkg::ST_LOAD && cnt_a_r == '0 && cnt_b_r == '0 && !done_a_r && !done_b_r), "state not cleared after final beat")

endmodule

// ===== tb/sorted_set_merge_op_tb.sv =====
module sorted_set_merge_op_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ssm_pkg::*;

  // The mode register has a fourth code that the package does not name.
  // The block treats it as a difference.
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  localparam longint VAL_MIN = 64'sh8000_0000_0000_0000;
  localparam longint VAL_MAX = 64'sh7fff_ffff_ffff_ffff;

  localparam logic SEL_FIRST  = 1'b0;
  localparam logic SEL_SECOND = 1'b1;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  ssm_in_beat_t        in_beat;
  logic                out_valid;
  ssm_out_beat_t       out_beat;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [MODE_W-1:0]   cfg_data;

  sorted_set_merge_op DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_beat  (out_beat),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Shadow of the block: the two sets as they have been loaded so far, their end
  // marks, the drop flag and the mode register. The sets hold at most SET_DEPTH
  // entries each; anything past that only raises the drop flag.
  longint              first_set[$];
  longint              second_set[$];
  bit                  first_ended;
  bit                  second_ended;
  bit                  dropped;
  logic [MODE_W-1:0]   mode_shadow;

  // Result beats that the block still owes, oldest first.
  ssm_out_beat_t       merge_expect_q[$];

  int                  mismatch_cnt;
  int                  elems_loaded;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Safety net: a healthy run finishes in a small fraction of this time.
  initial begin
    #3_000_000;
    $display("FAIL sorted_set_merge_op");
    $finish;
  end

  function void log_error(string msg);
    if (mismatch_cnt < 10) $display("ERROR @%0t: %s", $realtime, msg);
    mismatch_cnt++;
  endfunction

  function void push_result(longint v, bit is_empty);
    ssm_out_beat_t r;
    r.out_value    = v;
    r.out_last     = 1'b0;
    r.result_empty = is_empty;
    r.overflow     = dropped;
    merge_expect_q.push_back(r);
  endfunction

  // Two-pointer merge over the loaded sets, in whatever order they arrived.
  // Equal heads advance both pointers; otherwise the smaller head advances.
  function void predict_merge();
    int  i;
    int  j;
    int  n;
    bit  keep_first_only;
    bit  keep_second_only;
    bit  keep_common;
    i = 0;
    j = 0;
    n = 0;
    keep_first_only  = (mode_shadow == MODE_UNION) || (mode_shadow >= MODE_DIFF);
    keep_second_only = (mode_shadow == MODE_UNION);
    keep_common      = (mode_shadow <= MODE_INTERSECT);
    while (i < first_set.size() && j < second_set.size()) begin
      if (first_set[i] == second_set[j]) begin
        if (keep_common) begin
          push_result(first_set[i], 1'b0);
          n++;
        end
        i++;
        j++;
      end else if (first_set[i] < second_set[j]) begin
        if (keep_first_only) begin
          push_result(first_set[i], 1'b0);
          n++;
        end
        i++;
      end else begin
        if (keep_second_only) begin
          push_result(second_set[j], 1'b0);
          n++;
        end
        j++;
      end
    end
    if (keep_first_only) begin
      while (i < first_set.size()) begin
        push_result(first_set[i], 1'b0);
        n++;
        i++;
      end
    end
    if (keep_second_only) begin
      while (j < second_set.size()) begin
        push_result(second_set[j], 1'b0);
        n++;
        j++;
      end
    end
    // An empty result still produces one beat, flagged as empty.
    if (n == 0) push_result(0, 1'b1);
    merge_expect_q[merge_expect_q.size()-1].out_last = 1'b1;
  endfunction

  // Applies one accepted element beat to the shadow. A beat for a set that has
  // already ended is ignored while the other set is still loading.
  function void load_elem(ssm_in_beat_t b);
    if (b.set_sel == SEL_FIRST) begin
      if (first_ended) return;
      if (first_set.size() < SET_DEPTH) first_set.push_back(b.elem_value);
      else dropped = 1'b1;
      if (b.elem_last) first_ended = 1'b1;
    end else begin
      if (second_ended) return;
      if (second_set.size() < SET_DEPTH) second_set.push_back(b.elem_value);
      else dropped = 1'b1;
      if (b.elem_last) second_ended = 1'b1;
    end
    elems_loaded++;
    if (first_ended && second_ended) begin
      predict_merge();
      first_set.delete();
      second_set.delete();
      first_ended  = 1'b0;
      second_ended = 1'b0;
      dropped      = 1'b0;
    end
  endfunction

  // Result checker. Every strobed beat must match the oldest expectation; the
  // value field is only meaningful when the result is not empty.
  always @(posedge clk) begin : result_check
    ssm_out_beat_t want;
    if (rst_n && out_valid) begin
      if (merge_expect_q.size() == 0) begin
        log_error($sformatf("unexpected result beat value=%0d last=%0b empty=%0b ovf=%0b",
                            out_beat.out_value, out_beat.out_last,
                            out_beat.result_empty, out_beat.overflow));
      end else begin
        want = merge_expect_q.pop_front();
        if (out_beat.out_last !== want.out_last ||
            out_beat.result_empty !== want.result_empty ||
            out_beat.overflow !== want.overflow ||
            (!want.result_empty && out_beat.out_value !== want.out_value)) begin
          log_error($sformatf({"result mismatch: expected value=%0d last=%0b empty=%0b",
                               " ovf=%0b, got value=%0d last=%0b empty=%0b ovf=%0b"},
                              want.out_value, want.out_last, want.result_empty,
                              want.overflow, out_beat.out_value, out_beat.out_last,
                              out_beat.result_empty, out_beat.overflow));
        end
      end
    end
  end

  // Mostly back-to-back beats, some short gaps and the occasional long one.
  function int pick_gap(bit no_gaps);
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Sends one element beat. Called and returning at a falling edge. Start stays
  // high on return so that a following beat with no gap goes out back to back.
  task automatic send_elem(input logic sel, input longint v, input logic last,
                           input int gap);
    ssm_in_beat_t b;
    b.set_sel    = sel;
    b.elem_value = v;
    b.elem_last  = last;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   <= 1'b1;
    in_beat <= b;
    do @(posedge clk); while (busy);
    load_elem(b);
    @(negedge clk);
  endtask

  // Holds the sender off until every owed result beat has come out, then lets
  // the block settle.
  task automatic drain();
    start <= 1'b0;
    while (merge_expect_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Mode writes only happen with the block idle and no set partly loaded.
  task automatic write_mode(input logic [MODE_W-1:0] m);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    mode_shadow = m;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function longint rand_val(bit wide);
    int r;
    if (!wide) return longint'($urandom_range(0, 40)) - 20;
    r = $urandom_range(0, 15);
    if (r == 0) return VAL_MIN;
    if (r == 1) return VAL_MAX;
    return longint'({$urandom, $urandom});
  endfunction

  // One full operation: a sorted pool of distinct values is split between the
  // two sets (some values in both), then the two sets are sent interleaved at
  // random. Optionally the sets are shuffled, and optionally stray beats for an
  // already ended set are slipped in while the other set is still loading.
  task automatic run_pair(input int pool_n, input bit wide, input bit unordered,
                          input bit noisy, input bit no_gaps);
    longint pool[$];
    longint a_vals[$];
    longint b_vals[$];
    int     ia;
    int     ib;
    int     r;
    bit     take_a;
    repeat (pool_n) pool.push_back(rand_val(wide));
    pool.sort();
    pool = pool.unique();
    foreach (pool[k]) begin
      r = $urandom_range(0, 3);
      if (r != 1) a_vals.push_back(pool[k]);
      if (r != 0) b_vals.push_back(pool[k]);
    end
    // A set can only end on an element, so neither set may be left empty.
    if (a_vals.size() == 0) a_vals.push_back(pool[0]);
    if (b_vals.size() == 0) b_vals.push_back(pool[0]);
    if (unordered) begin
      a_vals.shuffle();
      b_vals.shuffle();
    end
    ia = 0;
    ib = 0;
    while (ia < a_vals.size() || ib < b_vals.size()) begin
      take_a = (ib >= b_vals.size()) || (ia < a_vals.size() && $urandom_range(0, 1) == 1);
      if (noisy && (ia >= a_vals.size() || ib >= b_vals.size()) &&
          $urandom_range(0, 4) == 0) begin
        send_elem((ia >= a_vals.size()) ? SEL_FIRST : SEL_SECOND, rand_val(1'b1),
                  logic'($urandom_range(0, 1)), pick_gap(no_gaps));
      end
      if (take_a) begin
        send_elem(SEL_FIRST, a_vals[ia], ia == a_vals.size() - 1, pick_gap(no_gaps));
        ia++;
      end else begin
        send_elem(SEL_SECOND, b_vals[ib], ib == b_vals.size() - 1, pick_gap(no_gaps));
        ib++;
      end
    end
  endtask

  // Union over the extreme values, with the sets interleaved and a shared
  // element in the middle.
  task automatic test_union_extremes();
    write_mode(MODE_UNION);
    send_elem(SEL_FIRST,  VAL_MIN, 1'b0, 0);
    send_elem(SEL_SECOND, 5,       1'b0, 0);
    send_elem(SEL_FIRST,  -1,      1'b0, 1);
    send_elem(SEL_SECOND, VAL_MAX, 1'b1, 0);
    send_elem(SEL_FIRST,  5,       1'b1, 0);
  endtask

  // Intersection with nothing in common gives the single empty beat. A beat for
  // the first set after it ended must be ignored while the second still loads.
  task automatic test_intersect_and_ignored();
    write_mode(MODE_INTERSECT);
    send_elem(SEL_FIRST,  0,  1'b1, 0);
    send_elem(SEL_FIRST,  9,  1'b1, 0);
    send_elem(SEL_SECOND, 1,  1'b1, 0);
    send_elem(SEL_FIRST,  -3, 1'b0, 2);
    send_elem(SEL_FIRST,  4,  1'b1, 0);
    send_elem(SEL_SECOND, 4,  1'b1, 0);
  endtask

  // Difference of equal sets is empty; the spare mode code acts as difference.
  // The second case ends the second set before the first one begins.
  task automatic test_difference_modes();
    write_mode(MODE_DIFF);
    send_elem(SEL_FIRST,  3, 1'b0, 0);
    send_elem(SEL_SECOND, 3, 1'b0, 0);
    send_elem(SEL_SECOND, 7, 1'b1, 0);
    send_elem(SEL_FIRST,  7, 1'b1, 0);
    write_mode(MODE_SPARE);
    send_elem(SEL_SECOND, 2, 1'b1, 0);
    send_elem(SEL_FIRST,  1, 1'b0, 0);
    send_elem(SEL_FIRST,  2, 1'b1, 0);
  endtask

  // A first set out of order: the merge still runs pointer by pointer.
  task automatic test_unordered();
    write_mode(MODE_UNION);
    send_elem(SEL_FIRST,  5, 1'b0, 0);
    send_elem(SEL_FIRST,  1, 1'b1, 0);
    send_elem(SEL_SECOND, 1, 1'b1, 0);
  endtask

  // Both sets one element longer than the store, interleaved: the excess of each
  // is dropped, the union fills the most result beats an operation can give and
  // every one of them carries the overflow flag.
  task automatic test_overflow();
    write_mode(MODE_UNION);
    for (int k = 0; k <= SET_DEPTH; k++) begin
      send_elem(SEL_FIRST,  2 * k,     k == SET_DEPTH, 0);
      send_elem(SEL_SECOND, 2 * k + 1, k == SET_DEPTH, pick_gap(1'b0));
    end
  endtask

  // Mostly well-formed sets of random content and size, with the mode changed
  // now and then; a minority of operations are shuffled or carry stray beats.
  // The run stops once about 120 elements have been loaded in all.
  task automatic test_random();
    while (elems_loaded < 120) begin
      if ($urandom_range(0, 3) == 0) write_mode(MODE_W'($urandom_range(0, 3)));
      run_pair($urandom_range(1, 10), $urandom_range(0, 2) != 0,
               $urandom_range(0, 9) == 0, $urandom_range(0, 5) == 0,
               $urandom_range(0, 3) == 0);
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_beat      = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    mismatch_cnt = 0;
    elems_loaded = 0;
    first_ended  = 1'b0;
    second_ended = 1'b0;
    dropped      = 1'b0;
    mode_shadow  = MODE_UNION;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_union_extremes();
    test_intersect_and_ignored();
    test_difference_modes();
    test_unordered();
    test_overflow();
    test_random();

    // Let the last merge finish.
    drain();
    repeat (2 * SET_DEPTH + 8) @(negedge clk);
    if (mismatch_cnt == 0 && merge_expect_q.size() == 0) begin
      $display("PASS sorted_set_merge_op");
    end else begin
      $display("FAIL sorted_set_merge_op");
    end
    $finish;
  end

endmodule
